// ===== rtl/core/tsb_pkg.sv =====
`default_nettype none
package tsb_pkg;

  localparam int SEGMENT_BUFFER_BYTES = 2048;
  localparam int HDR_BYTES            = 20;
  localparam int PAYLOAD_LIMIT        = SEGMENT_BUFFER_BYTES - HDR_BYTES;
  localparam int CNT_W                = $clog2(SEGMENT_BUFFER_BYTES);
  localparam int OFS_W                = 11;
  localparam int LEN_W                = 16;
  localparam int IDX_W                = $clog2(HDR_BYTES);
  localparam int QDEPTH               = 4;
  localparam int QPTR_W               = $clog2(QDEPTH);
  localparam int CS_CYCLES            = 9;
  localparam int CS_CNT_W             = $clog2(CS_CYCLES + 1);

  localparam logic [7:0]  DATA_OFFSET_BYTE = 8'h50;
  localparam logic [15:0] PROTO_TCP        = 16'd6;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_PAYLOAD = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  tcp_flags;
    logic [15:0] window_size;
    logic [15:0] urgent_pointer;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [OFS_W-1:0] out_offset;
    logic             out_last;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] urgent;
  } hdr_t;

  // one queue entry: either a payload echo or a finish snapshot
  typedef struct packed {
    logic             is_fin;
    logic [7:0]       pl_byte;
    logic [OFS_W-1:0] pl_offset;
    logic             ovf;
    hdr_t             hdr;
    logic [16:0]      run_sum;
    logic [LEN_W-1:0] len;
    logic [7:0]       pend;
    logic             odd;
  } q_entry_t;

  function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
    logic [17:0] t;
    t = {1'b0, s} + {2'b00, w};
    return 17'({1'b0, t[15:0]} + {15'd0, t[17:16]});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tsb_front.sv =====
`default_nettype none
module tsb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire tsb_pkg::in_item_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output tsb_pkg::q_entry_t      q_entry
);
  import tsb_pkg::*;

  hdr_t             hdr_r, hdr_nxt;
  logic [16:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic             odd_r, odd_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  logic             at_limit;
  logic [LEN_W-1:0] seg_len;

  assign accept   = in_push & ~q_full;
  assign at_limit = cnt_r >= CNT_W'(PAYLOAD_LIMIT);
  assign seg_len  = LEN_W'(HDR_BYTES) + LEN_W'(cnt_r);

  always_comb begin
    q_entry.is_fin    = (cmd_t'(in_data.cmd) == CMD_FINISH);
    q_entry.pl_byte   = in_data.payload_byte;
    q_entry.pl_offset = seg_len[OFS_W-1:0];
    q_entry.ovf       = ovf_r;
    q_entry.hdr       = hdr_r;
    q_entry.run_sum   = sum_r;
    q_entry.len       = seg_len;
    q_entry.pend      = pend_r;
    q_entry.odd       = odd_r;
  end

  always_comb begin
    hdr_nxt  = hdr_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    odd_nxt  = odd_r;
    ovf_nxt  = ovf_r;
    q_push   = 1'b0;
    if (accept) begin
      case (cmd_t'(in_data.cmd))
        CMD_HEADER: begin
          hdr_nxt.src_ip   = in_data.src_ip;
          hdr_nxt.dst_ip   = in_data.dst_ip;
          hdr_nxt.src_port = in_data.src_port;
          hdr_nxt.dst_port = in_data.dst_port;
          hdr_nxt.seq      = in_data.seq_num;
          hdr_nxt.ack      = in_data.ack_num;
          hdr_nxt.flags    = in_data.tcp_flags;
          hdr_nxt.window   = in_data.window_size;
          hdr_nxt.urgent   = in_data.urgent_pointer;
          sum_nxt          = '0;
          cnt_nxt          = '0;
          pend_nxt         = '0;
          odd_nxt          = 1'b0;
          ovf_nxt          = 1'b0;
        end
        CMD_PAYLOAD: begin
          if (at_limit) begin
            ovf_nxt = 1'b1;
          end else begin
            if (odd_r) begin
              sum_nxt = oc_add(sum_r, {pend_r, in_data.payload_byte});
              odd_nxt = 1'b0;
            end else begin
              pend_nxt = in_data.payload_byte;
              odd_nxt  = 1'b1;
            end
            cnt_nxt = cnt_r + CNT_W'(1);
            q_push  = 1'b1;
          end
        end
        CMD_FINISH: begin
          q_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      pend_r <= '0;
      odd_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      hdr_r  <= hdr_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      odd_r  <= odd_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsb_queue.sv =====
`default_nettype none
module tsb_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tsb_pkg::q_entry_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output tsb_pkg::q_entry_t      head,
  output logic                   valid
);
  import tsb_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign valid   = cnt_r != '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tsb_back.sv =====
`default_nettype none
module tsb_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsb_pkg::q_entry_t q_head,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output tsb_pkg::out_item_t     out_data
);
  import tsb_pkg::*;

  q_entry_t            fin_r, fin_nxt;
  logic                busy_r, busy_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [16:0]         cs_sum_r, cs_sum_nxt;
  logic [CS_CNT_W-1:0] cs_cnt_r, cs_cnt_nxt;
  logic                empty_r, empty_nxt;
  out_item_t           out_r, out_nxt;

  logic                slot_free;
  logic                cs_done;
  logic [15:0]         cs_final;
  logic [4:0]          cs_k;
  logic                hdr_ok;

  function automatic logic [15:0] cs_word(input q_entry_t f, input logic [4:0] k);
    logic [15:0] w;
    case (k)
      5'd0:    w = f.odd ? {f.pend, 8'h00} : 16'h0000;
      5'd1:    w = f.hdr.src_ip[31:16];
      5'd2:    w = f.hdr.src_ip[15:0];
      5'd3:    w = f.hdr.dst_ip[31:16];
      5'd4:    w = f.hdr.dst_ip[15:0];
      5'd5:    w = PROTO_TCP;
      5'd6:    w = f.len;
      5'd7:    w = {f.hdr.src_port[7:0], f.hdr.src_port[15:8]};
      5'd8:    w = {f.hdr.dst_port[7:0], f.hdr.dst_port[15:8]};
      5'd9:    w = f.hdr.seq[31:16];
      5'd10:   w = f.hdr.seq[15:0];
      5'd11:   w = f.hdr.ack[31:16];
      5'd12:   w = f.hdr.ack[15:0];
      5'd13:   w = {DATA_OFFSET_BYTE, f.hdr.flags};
      5'd14:   w = f.hdr.window;
      5'd16:   w = f.hdr.urgent;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hdr_byte(input q_entry_t f, input logic [IDX_W-1:0] i,
                                          input logic [15:0] cs);
    logic [7:0] b;
    case (i)
      IDX_W'(0):  b = f.hdr.src_port[7:0];
      IDX_W'(1):  b = f.hdr.src_port[15:8];
      IDX_W'(2):  b = f.hdr.dst_port[7:0];
      IDX_W'(3):  b = f.hdr.dst_port[15:8];
      IDX_W'(4):  b = f.hdr.seq[31:24];
      IDX_W'(5):  b = f.hdr.seq[23:16];
      IDX_W'(6):  b = f.hdr.seq[15:8];
      IDX_W'(7):  b = f.hdr.seq[7:0];
      IDX_W'(8):  b = f.hdr.ack[31:24];
      IDX_W'(9):  b = f.hdr.ack[23:16];
      IDX_W'(10): b = f.hdr.ack[15:8];
      IDX_W'(11): b = f.hdr.ack[7:0];
      IDX_W'(12): b = DATA_OFFSET_BYTE;
      IDX_W'(13): b = f.hdr.flags;
      IDX_W'(14): b = f.hdr.window[15:8];
      IDX_W'(15): b = f.hdr.window[7:0];
      IDX_W'(16): b = cs[15:8];
      IDX_W'(17): b = cs[7:0];
      IDX_W'(18): b = f.hdr.urgent[15:8];
      IDX_W'(19): b = f.hdr.urgent[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  assign slot_free = empty_r | out_pop;
  assign cs_done   = cs_cnt_r == CS_CNT_W'(CS_CYCLES);
  assign cs_final  = ~(cs_sum_r[15:0] + {15'd0, cs_sum_r[16]});
  assign cs_k      = {cs_cnt_r, 1'b0};
  // checksum bytes wait for the running fold to finish
  assign hdr_ok    = cs_done || (idx_r != IDX_W'(16) && idx_r != IDX_W'(17));

  assign out_empty = empty_r;
  assign out_data  = out_r;

  always_comb begin
    fin_nxt    = fin_r;
    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    cs_sum_nxt = cs_sum_r;
    cs_cnt_nxt = cs_cnt_r;
    out_nxt    = out_r;
    empty_nxt  = empty_r | out_pop;
    q_pop      = 1'b0;

    if (busy_r && !cs_done) begin
      cs_sum_nxt = oc_add(oc_add(cs_sum_r, cs_word(fin_r, cs_k)),
                          cs_word(fin_r, cs_k | 5'd1));
      cs_cnt_nxt = cs_cnt_r + CS_CNT_W'(1);
    end

    if (busy_r) begin
      if (slot_free && hdr_ok) begin
        out_nxt.out_byte   = hdr_byte(fin_r, idx_r, cs_final);
        out_nxt.out_offset = OFS_W'(idx_r);
        out_nxt.out_last   = idx_r == IDX_W'(HDR_BYTES - 1);
        out_nxt.overflow   = fin_r.ovf;
        empty_nxt          = 1'b0;
        idx_nxt            = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(HDR_BYTES - 1)) begin
          busy_nxt = 1'b0;
        end
      end
    end else if (q_valid) begin
      if (q_head.is_fin) begin
        q_pop      = 1'b1;
        fin_nxt    = q_head;
        busy_nxt   = 1'b1;
        idx_nxt    = '0;
        cs_sum_nxt = q_head.run_sum;
        cs_cnt_nxt = '0;
      end else if (slot_free) begin
        q_pop              = 1'b1;
        out_nxt.out_byte   = q_head.pl_byte;
        out_nxt.out_offset = q_head.pl_offset;
        out_nxt.out_last   = 1'b0;
        out_nxt.overflow   = q_head.ovf;
        empty_nxt          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    cs_sum_r <= cs_sum_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      cs_cnt_r <= '0;
      empty_r  <= 1'b1;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      cs_cnt_r <= cs_cnt_nxt;
      empty_r  <= empty_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tcp_segment_builder.sv =====
`default_nettype none
// channel   ports                          transaction when
// input     in_push, in_full, in_data      in_push && !in_full
// result    out_pop, out_empty, out_data   out_pop && !out_empty
//
// header items give no result; payload bytes below PAYLOAD_LIMIT give one result
// each, later ones only set overflow; a byte stream runs at one byte per cycle
// unless in_full or out_pop stalls it. a finish gives 20 results; its checksum
// is folded two words a cycle in the back end as the first header bytes go out.
// a 4-entry queue holds work between front and back; in_full rises when it fills.
// synchronous active-low reset empties the queue and clears all segment state.
module tcp_segment_builder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire tsb_pkg::in_item_t  in_data,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output tsb_pkg::out_item_t      out_data
);
  import tsb_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_entry;
  q_entry_t q_head;

  assign in_full = q_full;

  tsb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  tsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  tsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tsb_pkg::*;

  class segment_checker;
    in_item_t    hdr;
    logic [16:0] sum_acc;
    int          pay_cnt;
    logic [7:0]  hi_byte;
    bit          odd;
    bit          ovf;
    out_item_t   expected_bytes[$];
    int          mismatches;

    function new();
      hdr        = '0;
      sum_acc    = '0;
      pay_cnt    = 0;
      hi_byte    = '0;
      odd        = 1'b0;
      ovf        = 1'b0;
      mismatches = 0;
    endfunction

    // end-around carry add of one 16-bit word
    function logic [16:0] fold_word(logic [16:0] acc, logic [15:0] w);
      logic [17:0] t;
      t = {1'b0, acc} + {2'b00, w};
      return 17'(t[15:0]) + 17'(t[17:16]);
    endfunction

    function void queue_byte(logic [7:0] b, int off, bit is_last);
      out_item_t e;
      e.out_byte   = b;
      e.out_offset = OFS_W'(off);
      e.out_last   = is_last;
      e.overflow   = ovf;
      expected_bytes.push_back(e);
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  hb [0:19];
      logic [16:0] s;
      logic [16:0] folded;
      logic [15:0] seg_len;
      case (it.cmd)
        CMD_HEADER: begin
          hdr     = it;
          sum_acc = '0;
          pay_cnt = 0;
          hi_byte = '0;
          odd     = 1'b0;
          ovf     = 1'b0;
        end
        CMD_PAYLOAD: begin
          if (pay_cnt >= PAYLOAD_LIMIT) begin
            ovf = 1'b1;
          end else begin
            if (odd) begin
              sum_acc = fold_word(sum_acc, {hi_byte, it.payload_byte});
              odd     = 1'b0;
            end else begin
              hi_byte = it.payload_byte;
              odd     = 1'b1;
            end
            queue_byte(it.payload_byte, HDR_BYTES + pay_cnt, 1'b0);
            pay_cnt++;
          end
        end
        CMD_FINISH: begin
          // ports go out low byte first, everything else big endian
          hb[0]  = hdr.src_port[7:0];
          hb[1]  = hdr.src_port[15:8];
          hb[2]  = hdr.dst_port[7:0];
          hb[3]  = hdr.dst_port[15:8];
          {hb[4], hb[5], hb[6], hb[7]}   = hdr.seq_num;
          {hb[8], hb[9], hb[10], hb[11]} = hdr.ack_num;
          hb[12] = DATA_OFFSET_BYTE;
          hb[13] = hdr.tcp_flags;
          {hb[14], hb[15]} = hdr.window_size;
          hb[16] = 8'h00;
          hb[17] = 8'h00;
          {hb[18], hb[19]} = hdr.urgent_pointer;
          seg_len = 16'(HDR_BYTES + pay_cnt);
          s = sum_acc;
          if (odd) s = fold_word(s, {hi_byte, 8'h00});
          s = fold_word(s, hdr.src_ip[31:16]);
          s = fold_word(s, hdr.src_ip[15:0]);
          s = fold_word(s, hdr.dst_ip[31:16]);
          s = fold_word(s, hdr.dst_ip[15:0]);
          s = fold_word(s, PROTO_TCP);
          s = fold_word(s, seg_len);
          for (int i = 0; i < HDR_BYTES; i += 2) s = fold_word(s, {hb[i], hb[i+1]});
          folded = 17'(s[15:0]) + 17'(s[16]);
          {hb[16], hb[17]} = ~folded[15:0];
          for (int i = 0; i < HDR_BYTES; i++) queue_byte(hb[i], i, i == HDR_BYTES - 1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none actual %h", $time, got);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        $display("%0t: out_byte at offset %0d expected %h actual %h", $time,
                 want.out_offset, want.out_byte, got.out_byte);
      end
      if (got.out_offset !== want.out_offset) begin
        mismatches++;
        $display("%0t: out_offset expected %0d actual %0d", $time,
                 want.out_offset, got.out_offset);
      end
      if (got.out_last !== want.out_last) begin
        mismatches++;
        $display("%0t: out_last at offset %0d expected %b actual %b", $time,
                 want.out_offset, want.out_last, got.out_last);
      end
      if (got.overflow !== want.overflow) begin
        mismatches++;
        $display("%0t: overflow at offset %0d expected %b actual %b", $time,
                 want.out_offset, want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_item_t out_data;

  segment_checker chk = new();
  bit             steady = 1'b0;
  int             accepted_items = 0;

  tcp_segment_builder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) chk.check_result(out_data);
    out_pop <= rst_n && (steady || $urandom_range(99) >= 7);
  end

  function automatic in_item_t rand_item(cmd_t c);
    in_item_t it;
    it.cmd            = c;
    it.src_ip         = $urandom;
    it.dst_ip         = $urandom;
    it.src_port       = 16'($urandom);
    it.dst_port       = 16'($urandom);
    it.seq_num        = $urandom;
    it.ack_num        = $urandom;
    it.tcp_flags      = 8'($urandom);
    it.window_size    = 16'($urandom);
    it.urgent_pointer = 16'($urandom);
    it.payload_byte   = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b);
    in_item_t it;
    it = rand_item(CMD_PAYLOAD);
    it.payload_byte = b;
    return it;
  endfunction

  function automatic in_item_t flat_header(bit ones);
    in_item_t it;
    it = ones ? '1 : '0;
    it.cmd = CMD_HEADER;
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    if (!steady && $urandom_range(99) < 7) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    chk.note_input(it);
    if (it.cmd != CMD_RSVD) accepted_items++;
  endtask

  // hold the sender until every pending result has been popped
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (chk.expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic send_segment(int n_pay, bit twice);
    push_item(rand_item(CMD_HEADER));
    for (int k = 0; k < n_pay; k++) push_item(rand_item(CMD_PAYLOAD));
    push_item(rand_item(CMD_FINISH));
    if (twice) push_item(rand_item(CMD_FINISH));
  endtask

  initial begin
    in_item_t rsvd;
    int       sel;
    int       n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // payload with no header yet, odd length finish
    push_item(byte_item(8'hA5));
    push_item(rand_item(CMD_FINISH));
    rsvd = '1;
    rsvd.cmd = CMD_RSVD;
    push_item(rsvd);
    // all-ones header, repeated finish, payload after finish
    push_item(flat_header(1'b1));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'h00));
    push_item(byte_item(8'hFF));
    push_item(rand_item(CMD_FINISH));
    push_item(rand_item(CMD_FINISH));
    push_item(byte_item(8'h00));
    push_item(rand_item(CMD_FINISH));
    // all-zeros header, empty segment
    push_item(flat_header(1'b0));
    push_item(rand_item(CMD_FINISH));
    push_item(flat_header(1'b1));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'hFF));
    push_item(rand_item(CMD_FINISH));
    settle();

    while (accepted_items < 410) begin
      steady = (accepted_items >= 150) && (accepted_items < 260);
      sel = $urandom_range(99);
      if (sel < 8) settle();
      if (sel < 80) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 0);
        if (n > 410 - accepted_items) n = 410 - accepted_items;
        send_segment(n, $urandom_range(4) == 0);
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(3, 1)) push_item(rand_item(CMD_PAYLOAD));
          push_item(rand_item(CMD_FINISH));
        end
      end else begin
        push_item(rand_item(cmd_t'(2'($urandom_range(3)))));
      end
    end
    steady = 1'b0;

    settle();
    repeat (60) @(posedge clk);
    if (chk.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
